@@ rtl/core/bta_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the index allocator
// no dependencies

package bta_pkg;

	localparam int HEIGHT_W = 4;
	localparam int ACT_W    = 2;
	localparam int STATUS_W = 2;

	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 4'd10;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLAIM   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_FIND    = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OCCUPIED = 2'd1,
		ST_NONE     = 2'd2
	} result_code_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_MODIFY
	} fsm_t;

endpackage

@@ rtl/core/binary_trie_index_allocator.sv @@
`timescale 1ns / 1ps
// Index slot allocator over 2^tree_height slots. Each request claims a given
// slot, releases one, or finds the lowest free slot, and gives exactly one
// result (status and free_index). Occupancy lives in a ram of WORD_BITS-wide
// words; a flop summary marks full words so a find goes straight to the
// lowest word with room. A request first reads its word from the occupancy
// ram on the accept edge (registered read), then modifies it, writes it back
// and registers the result in the modify step; the next request is taken
// only after that write, so the read-modify-write never overlaps.
// A result waiting on out_stall holds the block in its modify step. The ram
// needs no clearing pass: per-word valid bits make it read as empty after
// reset. Depends on bta_pkg, bta_word_ram and bta_summary.

module binary_trie_index_allocator #(
	parameter int INDEX_BITS = 10,
	parameter int WORD_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: tree_height
	input  logic                          cfg_we,
	input  logic [bta_pkg::HEIGHT_W-1:0]  cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bta_pkg::ACT_W-1:0]     action,
	input  logic [INDEX_BITS-1:0]         entry_index,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bta_pkg::STATUS_W-1:0]  status,
	output logic [INDEX_BITS-1:0]         free_index
);

	localparam int SLOT_COUNT = 2 ** INDEX_BITS;
	localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int WORD_SEL   = $clog2(WORD_BITS);
	localparam int EH_W       = $clog2(INDEX_BITS + 1);

	// pattern of a word with every slot taken
	localparam logic [WORD_BITS-1:0] FULL_MASK = (SLOT_COUNT >= WORD_BITS) ?
		{WORD_BITS{1'b1}} : ~({WORD_BITS{1'b1}} << SLOT_COUNT);

	bta_pkg::fsm_t state_q, state_d;

	logic [bta_pkg::HEIGHT_W-1:0] tree_height_q;

	// effective height and the derived limits
	logic [EH_W-1:0]       h_eff;
	logic [INDEX_BITS:0]   limit;
	logic [INDEX_BITS:0]   lim_words;
	logic [INDEX_BITS-1:0] idx_eff;
	logic [WORD_BITS-1:0]  wmask;
	logic [WORD_COUNT-1:0] in_range;

	logic              sum_hit;
	logic [ADDR_W-1:0] sum_hit_addr;

	logic              in_accept;
	logic              out_free;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_BITS-1:0] rd_word;

	// request held across the modify step
	logic [bta_pkg::ACT_W-1:0] act_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic [WORD_SEL-1:0]       pos_s1;
	logic                      hit_s1;
	logic [WORD_BITS-1:0]      wmask_s1;

	// modify step
	logic                          commit;
	logic                          wr_req;
	logic [WORD_BITS-1:0]          new_word;
	logic [WORD_BITS-1:0]          bit_vec;
	logic [WORD_BITS-1:0]          avail;
	logic [WORD_SEL-1:0]           avail_pos;
	logic [bta_pkg::STATUS_W-1:0]  status_d;
	logic [INDEX_BITS-1:0]         found_d;

	logic                          out_valid_q;
	logic [bta_pkg::STATUS_W-1:0]  status_q;
	logic [INDEX_BITS-1:0]         free_index_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_height_q <= bta_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			tree_height_q <= cfg_wdata;
		end
	end

	// height clamped to 1..INDEX_BITS, index bits above it dropped
	always_comb begin
		if (tree_height_q == '0) begin
			h_eff = EH_W'(1);
		end else if (int'(tree_height_q) > INDEX_BITS) begin
			h_eff = EH_W'(INDEX_BITS);
		end else begin
			h_eff = EH_W'(tree_height_q);
		end
		limit     = (INDEX_BITS + 1)'(1) << h_eff;
		lim_words = limit >> WORD_SEL;
		idx_eff   = entry_index & ~({INDEX_BITS{1'b1}} << h_eff);
		// a find only looks at slots below the limit
		if (int'(h_eff) >= WORD_SEL) begin
			wmask = {WORD_BITS{1'b1}};
		end else begin
			wmask = ~({WORD_BITS{1'b1}} << (WORD_SEL + 1)'(limit));
		end
		for (int w = 0; w < WORD_COUNT; w++) begin
			in_range[w] = (w == 0) || ((INDEX_BITS + 1)'(w) < lim_words);
		end
	end

	bta_summary #(
		.WORD_COUNT (WORD_COUNT),
		.ADDR_W     (ADDR_W)
	) u_summary (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_range (in_range),
		.hit      (sum_hit),
		.hit_addr (sum_hit_addr),
		.upd_en   (commit && wr_req),
		.upd_addr (addr_s1),
		.upd_full (new_word == FULL_MASK)
	);

	// find reads the summary's pick, claim and release read their own word
	assign rd_addr = (action == bta_pkg::ACT_FIND) ? sum_hit_addr :
		ADDR_W'(idx_eff >> WORD_SEL);

	bta_word_ram #(
		.DEPTH  (WORD_COUNT),
		.ADDR_W (ADDR_W),
		.WIDTH  (WORD_BITS)
	) u_word_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word),
		.wr_en   (commit && wr_req),
		.wr_addr (addr_s1),
		.wr_data (new_word)
	);

	// control: next state
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bta_pkg::FSM_IDLE: begin
				if (in_valid) begin
					state_d = bta_pkg::FSM_MODIFY;
				end
			end
			bta_pkg::FSM_MODIFY: begin
				if (out_free) begin
					state_d = bta_pkg::FSM_IDLE;
				end
			end
			default: state_d = bta_pkg::FSM_IDLE;
		endcase
	end

	// control: outputs
	always_comb begin
		in_stall = 1'b1;
		commit   = 1'b0;
		case (state_q)
			bta_pkg::FSM_IDLE:   in_stall = 1'b0;
			bta_pkg::FSM_MODIFY: commit   = out_free;
			default: begin
				in_stall = 1'b1;
				commit   = 1'b0;
			end
		endcase
	end

	assign in_accept = in_valid && !in_stall;
	assign rd_en     = in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bta_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_s1   <= action;
			addr_s1  <= rd_addr;
			pos_s1   <= WORD_SEL'(idx_eff);
			hit_s1   <= sum_hit;
			wmask_s1 <= wmask;
		end
	end

	// lowest free bit of the word read for a find
	always_comb begin
		avail     = ~rd_word & wmask_s1;
		avail_pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (avail[b]) begin
				avail_pos = WORD_SEL'(b);
			end
		end
	end

	// modify the word and form the result
	always_comb begin
		bit_vec  = WORD_BITS'(1) << pos_s1;
		wr_req   = 1'b0;
		new_word = rd_word;
		status_d = bta_pkg::ST_OK;
		found_d  = '0;
		case (act_s1)
			bta_pkg::ACT_CLAIM: begin
				if ((rd_word & bit_vec) != '0) begin
					status_d = bta_pkg::ST_OCCUPIED;
				end else begin
					wr_req   = 1'b1;
					new_word = rd_word | bit_vec;
				end
			end
			bta_pkg::ACT_RELEASE: begin
				wr_req   = 1'b1;
				new_word = rd_word & ~bit_vec;
			end
			bta_pkg::ACT_FIND: begin
				if (!hit_s1 || avail == '0) begin
					status_d = bta_pkg::ST_NONE;
				end else begin
					found_d = INDEX_BITS'({addr_s1, avail_pos});
				end
			end
			default: status_d = bta_pkg::ST_OK;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_d;
			free_index_q <= found_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign free_index = free_index_q;

	// an accepted request always moves into the modify step
	a_accept_modify: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == bta_pkg::FSM_MODIFY)
		else $error("accepted request did not enter modify step");

	// word and summary are only written in the modify step
	a_write_in_modify: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && wr_req) |-> state_q == bta_pkg::FSM_MODIFY)
		else $error("occupancy write outside modify step");

	// a new result only follows a modify step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == bta_pkg::FSM_MODIFY))
		else $error("result appeared without a modify step");

	// no-free result carries a zero index
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q != bta_pkg::ST_NONE) || (free_index_q == '0))
		else $error("no-free result with non-zero index");

endmodule

@@ rtl/core/bta_word_ram.sv @@
`timescale 1ns / 1ps
// occupancy word store: synchronous ram, registered read
// per-entry valid bits make never-written words read as zero after reset

module bta_word_ram #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5,
	parameter int WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_word_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

@@ rtl/core/bta_summary.sv @@
`timescale 1ns / 1ps
// full-word summary: one flop per occupancy word, lowest non-full word search
// no package dependencies

module bta_summary #(
	parameter int WORD_COUNT = 32,
	parameter int ADDR_W     = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [WORD_COUNT-1:0] in_range,
	output logic                  hit,
	output logic [ADDR_W-1:0]     hit_addr,
	input  logic                  upd_en,
	input  logic [ADDR_W-1:0]     upd_addr,
	input  logic                  upd_full
);

	logic [WORD_COUNT-1:0] full_q;
	logic [WORD_COUNT-1:0] cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (upd_en) begin
			full_q[upd_addr] <= upd_full;
		end
	end

	// lowest word in range that still has room
	always_comb begin
		cand     = in_range & ~full_q;
		hit      = |cand;
		hit_addr = '0;
		for (int w = WORD_COUNT - 1; w >= 0; w--) begin
			if (cand[w]) begin
				hit_addr = ADDR_W'(w);
			end
		end
	end

endmodule
